// ===== rtl/core/lrsv_pkg.sv =====
// Shared types, constants and the CRC byte step for the log record stream validator.
`timescale 1ns / 1ps

package lrsv_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] FILE_MAGIC   = 64'h4C41_5741_4C4C_4543;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] REC_HDR_LEN  = 32'd20;
    localparam int          FILE_HDR_LEN = 16;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One queue entry holds everything that one input item causes.
    typedef struct packed {
        logic        has_report;
        logic [63:0] lsn;
        logic [31:0] start;
        logic [31:0] size;
        logic        has_summary;
        logic [31:0] vend;
        logic [31:0] trunc;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== rtl/core/lrsv_front.sv =====
// Front end: takes bytes, tracks the scan state, checks headers and CRC, queues results.
`timescale 1ns / 1ps

module lrsv_front #(
    parameter int OFFSET_BITS = lrsv_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_end_of_log,
    input  lrsv_pkg::queue_status_t q_status,
    output logic                    push,
    output lrsv_pkg::entry_t        push_entry
);

    localparam int SW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    typedef enum logic [4:0] {
        PH_FILE_HDR = 5'b00001,
        PH_HDR_SKIP = 5'b00010,
        PH_REC_HDR  = 5'b00100,
        PH_PAYLOAD  = 5'b01000,
        PH_STOPPED  = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [63:0]            header_reg, header_next;
    logic [31:0]            magic_reg, magic_next;
    logic [31:0]            size_reg, size_next;
    logic [31:0]            crc_hdr_reg, crc_hdr_next;
    logic [63:0]            lsn_reg, lsn_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            count_reg, count_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] good_reg, good_next;
    logic [31:0]            rec_magic_reg;

    logic                   accept;
    logic [OFFSET_BITS-1:0] pos;
    logic [31:0]            count_inc;
    logic [31:0]            crc_step;
    logic [SW-1:0]          end_sum;
    logic [OFFSET_BITS-1:0] rec_end;
    logic [OFFSET_BITS-1:0] trunc;
    logic [4:0]             lsn_lane;
    logic [63:0]            begin_wide;
    logic [63:0]            good_wide;
    logic [63:0]            trunc_wide;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;
    assign pos       = offset_reg;
    assign count_inc = count_reg + 32'd1;
    assign crc_step  = lrsv_pkg::crc_byte(crc_reg, s_data_byte);
    assign lsn_lane  = count_reg[4:0] - 5'd12;

    // Saturating end offset of the record that closes on this byte.
    assign end_sum = SW'(begin_reg) + SW'(size_reg);
    assign rec_end = (end_sum > SW'(OFF_MAX)) ? OFF_MAX : end_sum[OFFSET_BITS-1:0];

    assign begin_wide = 64'(begin_reg);

    always_comb begin
        phase_next   = phase_reg;
        offset_next  = (offset_reg == OFF_MAX) ? OFF_MAX : offset_reg + 1'b1;
        header_next  = header_reg;
        magic_next   = magic_reg;
        size_next    = size_reg;
        crc_hdr_next = crc_hdr_reg;
        lsn_next     = lsn_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        begin_next   = begin_reg;
        good_next    = good_reg;
        trunc        = '0;
        good_wide    = '0;
        trunc_wide   = '0;

        push_entry             = '0;
        push_entry.lsn         = lsn_reg;
        push_entry.start       = begin_wide[31:0];
        push_entry.size        = size_reg;

        unique case (phase_reg)
            PH_FILE_HDR: begin
                header_next = header_reg | (64'(s_data_byte) << {pos[2:0], 3'b000});
                if (pos == OFFSET_BITS'(7)) begin
                    if (header_next == lrsv_pkg::FILE_MAGIC) begin
                        phase_next = PH_HDR_SKIP;
                    end else begin
                        // Those eight bytes were the first record's magic and size.
                        phase_next   = PH_REC_HDR;
                        magic_next   = header_next[31:0];
                        size_next    = header_next[63:32];
                        crc_hdr_next = '0;
                        lsn_next     = '0;
                        crc_next     = lrsv_pkg::CRC_ONES;
                        count_next   = 32'd8;
                        begin_next   = '0;
                    end
                end
            end
            PH_HDR_SKIP: begin
                if (pos >= OFFSET_BITS'(lrsv_pkg::FILE_HDR_LEN - 1)) begin
                    begin_next   = OFFSET_BITS'(lrsv_pkg::FILE_HDR_LEN);
                    good_next    = OFFSET_BITS'(lrsv_pkg::FILE_HDR_LEN);
                    phase_next   = PH_REC_HDR;
                    magic_next   = '0;
                    size_next    = '0;
                    crc_hdr_next = '0;
                    lsn_next     = '0;
                    crc_next     = lrsv_pkg::CRC_ONES;
                    count_next   = '0;
                end
            end
            PH_REC_HDR: begin
                if (count_reg < 32'd4) begin
                    magic_next = magic_reg | (32'(s_data_byte) << {count_reg[1:0], 3'b000});
                end else if (count_reg < 32'd8) begin
                    size_next = size_reg | (32'(s_data_byte) << {count_reg[1:0], 3'b000});
                end else if (count_reg < 32'd12) begin
                    crc_hdr_next = crc_hdr_reg
                                 | (32'(s_data_byte) << {count_reg[1:0], 3'b000});
                end else if (count_reg < lrsv_pkg::REC_HDR_LEN) begin
                    lsn_next = lsn_reg | (64'(s_data_byte) << {lsn_lane[2:0], 3'b000});
                end
                count_next = count_inc;
                if (count_inc >= lrsv_pkg::REC_HDR_LEN) begin
                    if (magic_reg != rec_magic_reg || size_reg <= lrsv_pkg::REC_HDR_LEN) begin
                        phase_next = PH_STOPPED;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next   = crc_step;
                count_next = count_inc;
                if (count_inc == size_reg) begin
                    if ((crc_step ^ lrsv_pkg::CRC_ONES) == crc_hdr_reg) begin
                        push_entry.has_report = 1'b1;
                        good_next    = rec_end;
                        begin_next   = rec_end;
                        phase_next   = PH_REC_HDR;
                        magic_next   = '0;
                        size_next    = '0;
                        crc_hdr_next = '0;
                        lsn_next     = '0;
                        crc_next     = lrsv_pkg::CRC_ONES;
                        count_next   = '0;
                    end else begin
                        phase_next = PH_STOPPED;
                    end
                end
            end
            default: begin
                phase_next = PH_STOPPED;
            end
        endcase

        if (s_end_of_log) begin
            // The summary uses the file size and good end before the state clears.
            trunc      = (offset_next > good_next) ? (offset_next - good_next) : '0;
            good_wide  = 64'(good_next);
            trunc_wide = 64'(trunc);
            push_entry.has_summary = 1'b1;
            push_entry.vend        = good_wide[31:0];
            push_entry.trunc       = trunc_wide[31:0];
            // The next byte opens a new file.
            phase_next   = PH_FILE_HDR;
            offset_next  = '0;
            header_next  = '0;
            magic_next   = '0;
            size_next    = '0;
            crc_hdr_next = '0;
            lsn_next     = '0;
            crc_next     = lrsv_pkg::CRC_ONES;
            count_next   = '0;
            begin_next   = '0;
            good_next    = '0;
        end
    end

    assign push = accept && (push_entry.has_report || push_entry.has_summary);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FILE_HDR;
            offset_reg    <= '0;
            header_reg    <= '0;
            magic_reg     <= '0;
            size_reg      <= '0;
            crc_hdr_reg   <= '0;
            lsn_reg       <= '0;
            crc_reg       <= lrsv_pkg::CRC_ONES;
            count_reg     <= '0;
            begin_reg     <= '0;
            good_reg      <= '0;
            rec_magic_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rec_magic_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                offset_reg  <= offset_next;
                header_reg  <= header_next;
                magic_reg   <= magic_next;
                size_reg    <= size_next;
                crc_hdr_reg <= crc_hdr_next;
                lsn_reg     <= lsn_next;
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                begin_reg   <= begin_next;
                good_reg    <= good_next;
            end
        end
    end

endmodule

// ===== rtl/core/lrsv_queue.sv =====
// Short FIFO of result entries between the front end and the output stage.
`timescale 1ns / 1ps

module lrsv_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lrsv_pkg::entry_t        push_entry,
    input  logic                    pop,
    output lrsv_pkg::entry_t        head_entry,
    output lrsv_pkg::queue_status_t status
);

    localparam int DEPTH = lrsv_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lrsv_pkg::entry_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_entry   = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/lrsv_back.sv =====
// Back end: turns queue entries into result items in an output register.
`timescale 1ns / 1ps

module lrsv_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lrsv_pkg::entry_t        head_entry,
    input  lrsv_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_result_kind,
    output logic [63:0]             m_record_lsn,
    output logic [31:0]             m_record_start,
    output logic [31:0]             m_record_size,
    output logic [31:0]             m_good_end,
    output logic [31:0]             m_truncated_bytes,
    output logic                    m_last_of_run
);

    logic        valid_reg, valid_next;
    logic        sent_reg, sent_next;
    logic        kind_reg, kind_next;
    logic [63:0] lsn_reg, lsn_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] vend_reg, vend_next;
    logic [31:0] trunc_reg, trunc_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = !q_status.empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg && !m_ready;
        sent_next  = sent_reg;
        kind_next  = kind_reg;
        lsn_next   = lsn_reg;
        start_next = start_reg;
        size_next  = size_reg;
        vend_next  = vend_reg;
        trunc_next = trunc_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head_entry.has_report && !sent_reg) begin
                kind_next  = lrsv_pkg::KIND_REPORT;
                lsn_next   = head_entry.lsn;
                start_next = head_entry.start;
                size_next  = head_entry.size;
                vend_next  = '0;
                trunc_next = '0;
                last_next  = !head_entry.has_summary;
                // A summary behind the report keeps the entry for one more item.
                sent_next  = head_entry.has_summary;
                pop        = !head_entry.has_summary;
            end else begin
                kind_next  = lrsv_pkg::KIND_SUMMARY;
                lsn_next   = '0;
                start_next = '0;
                size_next  = '0;
                vend_next  = head_entry.vend;
                trunc_next = head_entry.trunc;
                last_next  = 1'b1;
                sent_next  = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        lsn_reg   <= lsn_next;
        start_reg <= start_next;
        size_reg  <= size_next;
        vend_reg  <= vend_next;
        trunc_reg <= trunc_next;
        last_reg  <= last_next;
    end

    assign m_valid           = valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_record_lsn      = lsn_reg;
    assign m_record_start    = start_reg;
    assign m_record_size     = size_reg;
    assign m_good_end        = vend_reg;
    assign m_truncated_bytes = trunc_reg;
    assign m_last_of_run     = last_reg;

endmodule

// ===== rtl/core/log_record_stream_validator_core.sv =====
// Top level of the log record stream validator: front end, result queue and output stage.
//
// The s_ channel takes one byte of a log file per item, s_end_of_log marking
// the final byte. The front end classifies every byte in the cycle it is
// accepted (file header check, record header capture, table-free CRC-32 byte
// step), so the block takes one byte per cycle while the result queue has room.
// Each good record yields a report on the m_ channel, and the final byte yields
// an end-of-file summary; m_last_of_run flags the last result of one byte.
// A result passes through the four-entry queue and then the output register
// after the byte that caused it. The output stage moves one result per cycle
// while the receiver is ready, so a byte that closes a record and the file yields two.
// When the receiver stalls, the queue fills and s_ready drops after four
// pending entries; bytes that cause no result pass freely until then.
// cfg_data writes the expected record magic and is always ready.
// Synchronous reset clears the scan state, the queue and the output register;
// the record magic returns to zero. After each summary the scan starts a new file.
`timescale 1ns / 1ps

module log_record_stream_validator_core #(
    parameter int OFFSET_BITS = lrsv_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_log,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [63:0] m_record_lsn,
    output logic [31:0] m_record_start,
    output logic [31:0] m_record_size,
    output logic [31:0] m_good_end,
    output logic [31:0] m_truncated_bytes,
    output logic        m_last_of_run
);

    lrsv_pkg::queue_status_t q_status;
    lrsv_pkg::entry_t        push_entry;
    lrsv_pkg::entry_t        head_entry;
    logic                    push;
    logic                    pop;

    lrsv_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_end_of_log(s_end_of_log),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    lrsv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head_entry(head_entry),
        .status    (q_status)
    );

    lrsv_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_entry       (head_entry),
        .q_status         (q_status),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_record_lsn     (m_record_lsn),
        .m_record_start   (m_record_start),
        .m_record_size    (m_record_size),
        .m_good_end       (m_good_end),
        .m_truncated_bytes(m_truncated_bytes),
        .m_last_of_run    (m_last_of_run)
    );

    // A summary always closes the run of results of its byte.
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == lrsv_pkg::KIND_SUMMARY) |-> m_last_of_run)
        else $error("summary item without last_of_run");

    // A report that is not last is followed at once by its summary.
    a_report_then_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_result_kind == lrsv_pkg::KIND_REPORT) && !m_last_of_run
        |=> m_valid && (m_result_kind == lrsv_pkg::KIND_SUMMARY))
        else $error("report not followed by its summary");

    // Only records with a nonempty payload are reported.
    a_report_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == lrsv_pkg::KIND_REPORT) |-> (m_record_size > 32'd20))
        else $error("report with record size below minimum");

    // A queued entry never sits behind an empty output register.
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_status.empty && !m_valid |-> pop || (head_entry.has_report && head_entry.has_summary))
        else $error("queue holds an entry while the output stage idles");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the log record stream validator core.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 115;
    localparam int SETTLE_TICKS = 8;

    typedef enum logic [2:0] {
        SCAN_FILE_HDR,
        SCAN_HDR_SKIP,
        SCAN_REC_HDR,
        SCAN_PAYLOAD,
        SCAN_STOPPED
    } scan_phase_e;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_CRC,
        FLAW_SIZE_MIN,
        FLAW_SIZE_LOW,
        FLAW_SIZE_HIGH
    } rec_flaw_e;

    typedef struct packed {
        logic [7:0] data;
        logic       eol;
    } log_byte_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] lsn;
        logic [31:0] start;
        logic [31:0] size;
        logic [31:0] vend;
        logic [31:0] trunc;
        logic        last;
    } log_result_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte  = '0;
    logic        s_end_of_log = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_result_kind;
    logic [63:0] m_record_lsn;
    logic [31:0] m_record_start;
    logic [31:0] m_record_size;
    logic [31:0] m_good_end;
    logic [31:0] m_truncated_bytes;
    logic        m_last_of_run;

    // Scanner state mirrored by the predictor.
    scan_phase_e sc_phase;
    logic [31:0] sc_offset;
    logic [63:0] sc_lead;
    logic [31:0] sc_magic;
    logic [31:0] sc_size;
    logic [31:0] sc_crc;
    logic [63:0] sc_lsn;
    logic [31:0] sc_run_crc;
    logic [31:0] sc_count;
    logic [31:0] sc_begin;
    logic [31:0] sc_good_end;
    logic [31:0] magic_cfg;

    logic [7:0]  file_buf[$];
    log_byte_t   log_bytes_q[$];
    log_result_t results_due[$];

    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int files_sent     = 0;
    int reports_seen   = 0;
    int summaries_seen = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int cycles         = 0;

    log_record_stream_validator_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_log      (s_end_of_log),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_record_lsn      (m_record_lsn),
        .m_record_start    (m_record_start),
        .m_record_size     (m_record_size),
        .m_good_end        (m_good_end),
        .m_truncated_bytes (m_truncated_bytes),
        .m_last_of_run     (m_last_of_run)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Reflected CRC-32, folding each data bit in as it reaches bit zero.
    function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (lrsv_pkg::CRC_POLY & {32{r[0] ^ d[k]}});
        end
        return r;
    endfunction

    function automatic string show_result(input log_result_t r);
        return $sformatf("kind=%0d lsn=%h start=%0d size=%0d end=%0d trunc=%0d last=%0d",
                         r.kind, r.lsn, r.start, r.size, r.vend, r.trunc, r.last);
    endfunction

    function automatic void scan_open_record();
        sc_magic   = '0;
        sc_size    = '0;
        sc_crc     = '0;
        sc_lsn     = '0;
        sc_run_crc = lrsv_pkg::CRC_ONES;
        sc_count   = '0;
        sc_phase   = SCAN_REC_HDR;
    endfunction

    function automatic void scan_reset_file();
        scan_open_record();
        sc_phase    = SCAN_FILE_HDR;
        sc_offset   = '0;
        sc_lead     = '0;
        sc_begin    = '0;
        sc_good_end = '0;
    endfunction

    // Advances the scanner by one accepted byte and queues the results it causes.
    function automatic void scan_byte(input logic [7:0] b, input logic eol);
        logic [31:0] pos;
        logic [31:0] lsn_idx;
        logic [32:0] sum;
        log_result_t rep;
        log_result_t summ;
        bit          has_rep;
        pos     = sc_offset;
        lsn_idx = sc_count - 32'd12;
        has_rep = 1'b0;
        rep     = '0;
        summ    = '0;
        if (sc_offset != '1) sc_offset = sc_offset + 32'd1;
        case (sc_phase)
            SCAN_FILE_HDR: begin
                if (pos < 8) sc_lead[{pos[2:0], 3'b000} +: 8] = b;
                if (pos >= 7) begin
                    if (sc_lead == lrsv_pkg::FILE_MAGIC) begin
                        sc_phase = SCAN_HDR_SKIP;
                    end else begin
                        // Without the file magic the lead bytes are the first record's
                        // magic and size.
                        scan_open_record();
                        sc_magic = sc_lead[31:0];
                        sc_size  = sc_lead[63:32];
                        sc_count = 32'd8;
                        sc_begin = '0;
                    end
                end
            end
            SCAN_HDR_SKIP: begin
                if (pos >= 32'(lrsv_pkg::FILE_HDR_LEN - 1)) begin
                    sc_begin    = 32'(lrsv_pkg::FILE_HDR_LEN);
                    sc_good_end = 32'(lrsv_pkg::FILE_HDR_LEN);
                    scan_open_record();
                end
            end
            SCAN_REC_HDR: begin
                if (sc_count < 4) sc_magic[{sc_count[1:0], 3'b000} +: 8] = b;
                else if (sc_count < 8) sc_size[{sc_count[1:0], 3'b000} +: 8] = b;
                else if (sc_count < 12) sc_crc[{sc_count[1:0], 3'b000} +: 8] = b;
                else if (sc_count < 20) sc_lsn[{lsn_idx[2:0], 3'b000} +: 8] = b;
                sc_count = sc_count + 32'd1;
                if (sc_count >= lrsv_pkg::REC_HDR_LEN) begin
                    if (sc_magic != magic_cfg || sc_size <= lrsv_pkg::REC_HDR_LEN) begin
                        sc_phase = SCAN_STOPPED;
                    end else begin
                        sc_phase = SCAN_PAYLOAD;
                    end
                end
            end
            SCAN_PAYLOAD: begin
                sc_run_crc = crc32_update(sc_run_crc, b);
                sc_count   = sc_count + 32'd1;
                if (sc_count == sc_size) begin
                    if (~sc_run_crc == sc_crc) begin
                        has_rep    = 1'b1;
                        rep.kind   = lrsv_pkg::KIND_REPORT;
                        rep.lsn    = sc_lsn;
                        rep.start  = sc_begin;
                        rep.size   = sc_size;
                        sum        = {1'b0, sc_begin} + {1'b0, sc_size};
                        sc_good_end = sum[32] ? '1 : sum[31:0];
                        sc_begin   = sc_good_end;
                        scan_open_record();
                    end else begin
                        sc_phase = SCAN_STOPPED;
                    end
                end
            end
            default: sc_phase = SCAN_STOPPED;
        endcase
        if (has_rep) begin
            rep.last = !eol;
            results_due.insert(results_due.size(), rep);
        end
        if (eol) begin
            summ.kind  = lrsv_pkg::KIND_SUMMARY;
            summ.vend  = sc_good_end;
            summ.trunc = (sc_offset > sc_good_end) ? sc_offset - sc_good_end : 32'd0;
            summ.last  = 1'b1;
            results_due.insert(results_due.size(), summ);
            scan_reset_file();
        end
    endfunction

    task automatic put_le(input logic [63:0] v, input int nbytes);
        for (int k = 0; k < nbytes; k++) begin
            file_buf.insert(file_buf.size(), v[8*k +: 8]);
        end
    endtask

    // Appends one record; fill < 0 gives a random payload, otherwise a constant one.
    task automatic add_record(input logic [31:0] magic, input int plen, input rec_flaw_e flaw,
                              input logic [63:0] lsn, input int fill);
        logic [7:0]  body[$];
        logic [7:0]  d;
        logic [31:0] crc;
        logic [31:0] size;
        logic [31:0] m;
        m   = magic;
        crc = lrsv_pkg::CRC_ONES;
        for (int k = 0; k < plen; k++) begin
            d   = (fill < 0) ? 8'($urandom) : fill[7:0];
            crc = crc32_update(crc, d);
            body.insert(body.size(), d);
        end
        crc  = ~crc;
        size = lrsv_pkg::REC_HDR_LEN + 32'(plen);
        case (flaw)
            FLAW_MAGIC:     m = magic ^ (32'd1 << $urandom_range(31));
            FLAW_CRC:       crc = crc ^ (32'd1 << $urandom_range(31));
            FLAW_SIZE_MIN:  size = lrsv_pkg::REC_HDR_LEN;
            FLAW_SIZE_LOW:  size = $urandom_range(19);
            FLAW_SIZE_HIGH: begin
                if ($urandom_range(9) == 0) size = '1;
                else size = size + 32'd1 + $urandom_range(40);
            end
            default: ;
        endcase
        put_le(64'(m), 4);
        put_le(64'(size), 4);
        put_le(64'(crc), 4);
        put_le(lsn, 8);
        foreach (body[k]) file_buf.insert(file_buf.size(), body[k]);
    endtask

    task automatic send_file();
        log_byte_t it;
        for (int k = 0; k < file_buf.size(); k++) begin
            it.data = file_buf[k];
            it.eol  = (k == file_buf.size() - 1);
            log_bytes_q.insert(log_bytes_q.size(), it);
        end
        bytes_queued += file_buf.size();
        files_sent++;
        file_buf.delete();
    endtask

    task automatic directed_files();
        // A file of one byte.
        file_buf.insert(file_buf.size(), 8'h00);
        send_file();
        // Eight bytes without the file magic; the end falls on the last lead byte.
        put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
        send_file();
        // The file magic, but the file ends before its header does.
        put_le(lrsv_pkg::FILE_MAGIC, 8);
        put_le(64'h0, 2);
        send_file();
        // File header and nothing else.
        put_le(lrsv_pkg::FILE_MAGIC, 8);
        put_le({$urandom, $urandom}, 8);
        send_file();
        // A single record whose last byte is the end of the file.
        add_record(magic_cfg, 1, FLAW_NONE, 64'h0, 0);
        send_file();
        // Header, two good records, a record of exactly header size, bytes after the stop.
        put_le(lrsv_pkg::FILE_MAGIC, 8);
        put_le({$urandom, $urandom}, 8);
        add_record(magic_cfg, 4, FLAW_NONE, '1, 255);
        add_record(magic_cfg, 3, FLAW_NONE, {$urandom, $urandom}, -1);
        add_record(magic_cfg, 2, FLAW_SIZE_MIN, {$urandom, $urandom}, -1);
        put_le({$urandom, $urandom}, 3);
        send_file();
        add_record(magic_cfg, 5, FLAW_NONE, {$urandom, $urandom}, -1);
        add_record(magic_cfg, 5, FLAW_MAGIC, {$urandom, $urandom}, -1);
        send_file();
        add_record(magic_cfg, 2, FLAW_NONE, {$urandom, $urandom}, -1);
        add_record(magic_cfg, 7, FLAW_CRC, {$urandom, $urandom}, -1);
        put_le({$urandom, $urandom}, 2);
        send_file();
        // The second record is cut off by the end of the file.
        add_record(magic_cfg, 3, FLAW_NONE, {$urandom, $urandom}, -1);
        add_record(magic_cfg, 6, FLAW_NONE, {$urandom, $urandom}, -1);
        repeat (4) void'(file_buf.pop_back());
        send_file();
        add_record(magic_cfg, 3, FLAW_SIZE_LOW, {$urandom, $urandom}, -1);
        send_file();
        add_record(magic_cfg, 3, FLAW_SIZE_HIGH, {$urandom, $urandom}, -1);
        send_file();
        // One flipped bit in the file magic turns the header into a record.
        put_le(lrsv_pkg::FILE_MAGIC ^ (64'd1 << $urandom_range(63)), 8);
        put_le({$urandom, $urandom}, 8);
        add_record(magic_cfg, 2, FLAW_NONE, {$urandom, $urandom}, -1);
        send_file();
    endtask

    task automatic random_file();
        int        pick;
        int        nrec;
        int        plen;
        int        cut;
        rec_flaw_e flaw;
        logic [63:0] lsn;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 40)) file_buf.insert(file_buf.size(), 8'($urandom));
        end else begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                put_le(lrsv_pkg::FILE_MAGIC, 8);
                put_le({$urandom, $urandom}, 8);
            end else if (pick < 36) begin
                put_le(lrsv_pkg::FILE_MAGIC ^ (64'd1 << $urandom_range(63)), 8);
                put_le({$urandom, $urandom}, 8);
            end
            nrec = $urandom_range(4);
            for (int k = 0; k < nrec; k++) begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
                flaw = ($urandom_range(99) < 88) ? FLAW_NONE
                                                 : rec_flaw_e'($urandom_range(1, 5));
                case ($urandom_range(19))
                    0:       lsn = '0;
                    1:       lsn = '1;
                    default: lsn = {$urandom, $urandom};
                endcase
                add_record(magic_cfg, plen, flaw, lsn, -1);
            end
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 6)) file_buf.insert(file_buf.size(), 8'($urandom));
            end
            cut = $urandom_range(1, 10);
            if ($urandom_range(99) < 12 && file_buf.size() > cut) begin
                repeat (cut) void'(file_buf.pop_back());
            end
            if (file_buf.size() == 0) file_buf.insert(file_buf.size(), 8'($urandom));
        end
        send_file();
    endtask

    task automatic write_magic(input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        magic_cfg = value;
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || results_due.size() != 0) @(posedge aclk);
    endtask

    // Byte driver: the predictor runs on every accepted item.
    always @(posedge aclk) begin : byte_driver
        log_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_data_byte, s_end_of_log);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (log_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = log_bytes_q.pop_front();
                    s_valid      <= 1'b1;
                    s_data_byte  <= nxt.data;
                    s_end_of_log <= nxt.eol;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        log_result_t got;
        log_result_t want;
        string       bad;
        if (aresetn && m_valid && m_ready) begin
            got.kind  = m_result_kind;
            got.lsn   = m_record_lsn;
            got.start = m_record_start;
            got.size  = m_record_size;
            got.vend  = m_good_end;
            got.trunc = m_truncated_bytes;
            got.last  = m_last_of_run;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: %s", show_result(got));
                end
            end else begin
                want = results_due.pop_front();
                bad  = "";
                if (got.kind  !== want.kind)  bad = {bad, " kind"};
                if (got.lsn   !== want.lsn)   bad = {bad, " lsn"};
                if (got.start !== want.start) bad = {bad, " start"};
                if (got.size  !== want.size)  bad = {bad, " size"};
                if (got.vend  !== want.vend)  bad = {bad, " good_end"};
                if (got.trunc !== want.trunc) bad = {bad, " truncated"};
                if (got.last  !== want.last)  bad = {bad, " last"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch in%s at %0t", bad, $realtime);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(got));
                    end
                end
                if (want.kind == lrsv_pkg::KIND_SUMMARY) summaries_seen++;
                else reports_seen++;
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] magic;
        int          budget;
        magic_cfg = '0;
        scan_reset_file();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       magic = '1;
                1:       magic = '0;
                4:       magic = 32'h0000_0001;
                5:       magic = 32'h8000_0000;
                default: magic = $urandom;
            endcase
            write_magic(magic);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 0) directed_files();
            budget = bytes_queued + PHASE_BYTES;
            while (bytes_queued < budget) random_file();
            wait_drained();
            // Bytes that cause no result may still be in the pipeline.
            repeat (SETTLE_TICKS) @(posedge aclk);
        end
        $display("Scanned %0d log files, %0d bytes, under %0d record magic values",
                 files_sent, bytes_queued, PHASES);
        $display("and four idling mixes: %0d record reports, %0d summaries, %0d mismatches.",
                 reports_seen, summaries_seen, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
